### design/phtr_pkg.sv
// Shared constants, types and channel packing functions for the hue tint recolor block.
package phtr_pkg;

  localparam int PIX_W      = 16;
  localparam int CH_W       = 8;
  localparam int SHIFT_W    = 4;
  localparam int LOSS_W     = 4;
  localparam int HUE_W      = 8;
  localparam int Q_W        = 16;
  localparam int CQ_W       = 14;
  localparam int HQ_W       = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int HUE_STEPS_DEFAULT = 256;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HUE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_LOSS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOSS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOSS   = 3'd6;

  typedef struct packed {
    logic [SHIFT_W-1:0] red_shift;
    logic [SHIFT_W-1:0] green_shift;
    logic [SHIFT_W-1:0] blue_shift;
    logic [LOSS_W-1:0]  red_loss;
    logic [LOSS_W-1:0]  green_loss;
    logic [LOSS_W-1:0]  blue_loss;
  } layout_t;

  function automatic logic [CH_W-1:0] unpack_ch(input logic [PIX_W-1:0] pix,
                                                input logic [SHIFT_W-1:0] shift,
                                                input logic [LOSS_W-1:0] loss);
    logic [PIX_W-1:0] moved;
    logic [CH_W-1:0]  field;
    moved = pix >> shift;
    field = moved[CH_W-1:0] & (8'hFF >> loss);
    return CH_W'(field << loss);
  endfunction

  function automatic logic [PIX_W-1:0] pack_ch(input logic [CH_W-1:0] ch,
                                               input logic [SHIFT_W-1:0] shift,
                                               input logic [LOSS_W-1:0] loss);
    logic [PIX_W-1:0] wide;
    wide = {8'd0, ch >> loss};
    return wide << shift;
  endfunction

  function automatic logic [PIX_W-1:0] pack3(input logic [CH_W-1:0] r,
                                             input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b,
                                             input layout_t lay);
    return pack_ch(r, lay.red_shift, lay.red_loss)
         | pack_ch(g, lay.green_shift, lay.green_loss)
         | pack_ch(b, lay.blue_shift, lay.blue_loss);
  endfunction

  // q * 255 / 65536, truncated; q stays below 65536 so the result fits 8 bits.
  function automatic logic [CH_W-1:0] q_to_8(input logic [Q_W-1:0] q);
    logic [Q_W+CH_W-1:0] t;
    t = {q, 8'd0} - {8'd0, q};
    return t[Q_W+CH_W-1:Q_W];
  endfunction

endpackage

### design/phtr_chan.sv
// Channel stage: unpack, optional inversion with repack, channel maximum and value in Q16.
module phtr_chan import phtr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] pix,
  input  logic             inv,
  input  layout_t          lay,
  output logic             vq_valid,
  output logic [Q_W-1:0]   vq
);

  logic [CH_W-1:0]  r_inv, g_inv, b_inv;
  logic [PIX_W-1:0] pix_src;
  logic [CH_W-1:0]  r, g, b, c;
  logic [13:0]      c64;
  logic [13:0]      frac_q;
  logic [Q_W-1:0]   vq_next;

  always_comb begin
    r_inv = 8'd255 - unpack_ch(pix, lay.red_shift, lay.red_loss);
    g_inv = 8'd255 - unpack_ch(pix, lay.green_shift, lay.green_loss);
    b_inv = 8'd255 - unpack_ch(pix, lay.blue_shift, lay.blue_loss);
    pix_src = inv ? pack3(r_inv, g_inv, b_inv, lay) : pix;

    r = unpack_ch(pix_src, lay.red_shift, lay.red_loss);
    g = unpack_ch(pix_src, lay.green_shift, lay.green_loss);
    b = unpack_ch(pix_src, lay.blue_shift, lay.blue_loss);
    c = r;
    if (g > c) begin
      c = g;
    end
    if (b > c) begin
      c = b;
    end

    // c * 16384 / 255 = c * 64 + (c * 64) / 255; the second term uses the
    // usual divide-by-255 identity, exact for arguments below 65535.
    c64 = {c, 6'd0};
    frac_q = 14'((16'(c64) + 16'(c64 >> 8) + 16'd1) >> 8);
    vq_next = 16'd32768 + 16'(c64) + 16'(frac_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq_valid <= 1'b0;
    end else begin
      vq_valid <= in_valid;
    end
    vq <= vq_next;
  end

endmodule

### design/phtr_tint.sv
// Tint stages: chroma, triangle term, sector select and repack of the result pixel.
module phtr_tint import phtr_pkg::*; #(
  parameter int HUE_STEPS = HUE_STEPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vq_valid,
  input  logic [Q_W-1:0]   vq,
  input  logic [HUE_W-1:0] hue_setting,
  input  layout_t          lay,
  output logic             done,
  output logic [PIX_W-1:0] pixel_out
);

  localparam logic [2:0] SEC_RED_UP     = 3'd0;
  localparam logic [2:0] SEC_GREEN_TOP  = 3'd1;
  localparam logic [2:0] SEC_BLUE_UP    = 3'd2;
  localparam logic [2:0] SEC_BLUE_TOP   = 3'd3;
  localparam logic [2:0] SEC_RED_RISE   = 3'd4;
  localparam logic [2:0] SEC_LAST       = 3'd5;
  localparam int         HUE_SCALE      = 6 * 65536;
  localparam int         HUE_VALUES     = 2 ** HUE_W;
  localparam logic [16:0] ONE_Q         = 17'd65536;
  localparam logic [16:0] RECIP_5       = 17'd52429;

  // Hue position in Q16 sixths of a turn for every register value, fixed at elaboration.
  logic [HQ_W-1:0] hq_table [HUE_VALUES];
  genvar h;
  for (h = 0; h < HUE_VALUES; h++) begin : g_hue
    assign hq_table[h] = HQ_W'((64'(h) * 64'(HUE_SCALE)) / 64'(HUE_STEPS));
  end

  // Hue terms depend on the register only.
  logic [HQ_W-1:0]      hq;
  logic [HQ_W-Q_W-1:0]  sector_raw;
  logic [2:0]           sector;
  logic [16:0]          hmod, hue_dist, tri_w;

  always_comb begin
    hq = hq_table[hue_setting];
    sector_raw = hq[HQ_W-1:Q_W];
    sector = (sector_raw > 11'd5) ? SEC_LAST : sector_raw[2:0];
    hmod = hq[16:0];
    hue_dist = hmod[16] ? hmod - ONE_Q : ONE_Q - hmod;
    tri_w = ONE_Q - hue_dist;
  end

  // Chroma: vq / 5 by reciprocal, exact for vq below 65536.
  logic [33:0]     cq_prod;
  logic            s2_valid;
  logic [Q_W-1:0]  vq2;
  logic [CQ_W-1:0] cq2;

  assign cq_prod = {1'b0, vq} * RECIP_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= vq_valid;
    end
    vq2 <= vq;
    cq2 <= cq_prod[31:18];
  end

  // Triangle term x = chroma * tri / 65536.
  logic [30:0]     xq_prod;
  logic            s3_valid;
  logic [Q_W-1:0]  vq3, mq3;
  logic [CQ_W-1:0] xq3;

  assign xq_prod = cq2 * tri_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    vq3 <= vq2;
    mq3 <= vq2 - Q_W'(cq2);
    xq3 <= xq_prod[29:16];
  end

  logic [Q_W-1:0]   mid, rq, gq, bq;
  logic [PIX_W-1:0] pixel_next;

  always_comb begin
    mid = Q_W'(xq3) + mq3;
    case (sector)
      SEC_RED_UP: begin
        rq = vq3; gq = mid; bq = mq3;
      end
      SEC_GREEN_TOP: begin
        rq = mid; gq = vq3; bq = mq3;
      end
      SEC_BLUE_UP: begin
        rq = mq3; gq = vq3; bq = mid;
      end
      SEC_BLUE_TOP: begin
        rq = mq3; gq = mid; bq = vq3;
      end
      SEC_RED_RISE: begin
        rq = mid; gq = mq3; bq = vq3;
      end
      default: begin
        rq = vq3; gq = mq3; bq = mid;
      end
    endcase
    pixel_next = pack3(q_to_8(rq), q_to_8(gq), q_to_8(bq), lay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
    pixel_out <= pixel_next;
  end

  // The reciprocal must give the exact quotient by five.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> ((19'(cq2) * 19'd5 <= 19'(vq2)) && (19'(vq2) < 19'(cq2) * 19'd5 + 19'd5)))
    else $error("chroma is not vq / 5");

  // The middle channel never passes the top channel.
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (17'(xq3) + 17'(mq3) <= 17'(vq3)))
    else $error("middle channel exceeds value");

  // The triangle term stays within one.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (tri_w <= ONE_Q))
    else $error("triangle term out of range");

endmodule

### design/pixel_hue_tint_recolor.sv
// A taken pixel passes input, value, chroma, triangle and output registers to done.
// Throughput: one pixel per cycle; busy is low whenever rst is low.
// The five register stages are set by the two multipliers (divide by five, triangle term).
// Reset (synchronous, rst high) clears pipeline valid bits and hue, loads default layout.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
module pixel_hue_tint_recolor import phtr_pkg::*; #(
  parameter int HUE_STEPS = HUE_STEPS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      pixel_in,
  input  logic                  invert,
  output logic                  done,
  output logic [PIX_W-1:0]      pixel_out,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [HUE_W-1:0] hue_setting;
  layout_t          lay;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_setting     <= 8'd0;
      lay.red_shift   <= 4'd11;
      lay.green_shift <= 4'd5;
      lay.blue_shift  <= 4'd0;
      lay.red_loss    <= 4'd3;
      lay.green_loss  <= 4'd2;
      lay.blue_loss   <= 4'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HUE:         hue_setting     <= cfg_data;
        REG_RED_SHIFT:   lay.red_shift   <= cfg_data[SHIFT_W-1:0];
        REG_GREEN_SHIFT: lay.green_shift <= cfg_data[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  lay.blue_shift  <= cfg_data[SHIFT_W-1:0];
        REG_RED_LOSS:    lay.red_loss    <= cfg_data[LOSS_W-1:0];
        REG_GREEN_LOSS:  lay.green_loss  <= cfg_data[LOSS_W-1:0];
        REG_BLUE_LOSS:   lay.blue_loss   <= cfg_data[LOSS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = rst;

  logic             accept;
  logic             in_valid;
  logic [PIX_W-1:0] pix;
  logic             inv;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    pix <= pixel_in;
    inv <= invert;
  end

  logic           vq_valid;
  logic [Q_W-1:0] vq;

  phtr_chan u_chan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .pix      (pix),
    .inv      (inv),
    .lay      (lay),
    .vq_valid (vq_valid),
    .vq       (vq)
  );

  phtr_tint #(
    .HUE_STEPS (HUE_STEPS)
  ) u_tint (
    .clk         (clk),
    .rst         (rst),
    .vq_valid    (vq_valid),
    .vq          (vq),
    .hue_setting (hue_setting),
    .lay         (lay),
    .done        (done),
    .pixel_out   (pixel_out)
  );

  // Every transfer in yields exactly one result on done.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("result missing after accepted pixel");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result without accepted pixel");

  // Value lies in [0.5, 0.75] of full scale.
  assert property (@(posedge clk) disable iff (rst)
    vq_valid |-> (vq >= 16'd32768 && vq <= 16'd49152))
    else $error("value out of range");

endmodule

### dv/pixel_hue_tint_recolor_tb.sv
// Self-checking testbench for the hue tint recolor block: directed and random pixels over many layouts.
`timescale 1ns / 100ps

module pixel_hue_tint_recolor_tb;
  import phtr_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;
  localparam int BLOCKS      = 14;
  localparam int BLOCK_ITEMS = 100;
  localparam int MAX_REPORTS = 200;

  // The block ignores this index; it is written to show that nothing else moves.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [HUE_W-1:0]   hue;
    logic [SHIFT_W-1:0] red_shift;
    logic [SHIFT_W-1:0] green_shift;
    logic [SHIFT_W-1:0] blue_shift;
    logic [LOSS_W-1:0]  red_loss;
    logic [LOSS_W-1:0]  green_loss;
    logic [LOSS_W-1:0]  blue_loss;
  } tint_setup_t;

  class recolor_scoreboard;
    logic [HUE_W-1:0]   hue;
    logic [SHIFT_W-1:0] red_shift, green_shift, blue_shift;
    logic [LOSS_W-1:0]  red_loss, green_loss, blue_loss;
    logic [PIX_W-1:0]   expected_pixels[$];
    int                 errors;

    function new();
      hue         = 8'd0;
      red_shift   = 4'd11;
      green_shift = 4'd5;
      blue_shift  = 4'd0;
      red_loss    = 4'd3;
      green_loss  = 4'd2;
      blue_loss   = 4'd3;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HUE:         hue         = data;
        REG_RED_SHIFT:   red_shift   = data[SHIFT_W-1:0];
        REG_GREEN_SHIFT: green_shift = data[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  blue_shift  = data[SHIFT_W-1:0];
        REG_RED_LOSS:    red_loss    = data[LOSS_W-1:0];
        REG_GREEN_LOSS:  green_loss  = data[LOSS_W-1:0];
        REG_BLUE_LOSS:   blue_loss   = data[LOSS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned field_of(int unsigned pix, logic [SHIFT_W-1:0] shift,
                                   logic [LOSS_W-1:0] loss);
      int unsigned mask;
      mask = (32'hFF >> loss) << shift;
      return (((pix & mask) >> shift) << loss) & 32'hFF;
    endfunction

    function int unsigned packed_pixel(int unsigned r, int unsigned g, int unsigned b);
      return (((r >> red_loss) << red_shift) | ((g >> green_loss) << green_shift)
            | ((b >> blue_loss) << blue_shift)) & 32'hFFFF;
    endfunction

    function int unsigned channel8(int unsigned q);
      longint unsigned v;
      v = (longint'(q) * 255) >> 16;
      return (v > 255) ? 255 : int'(v);
    endfunction

    function logic [PIX_W-1:0] recolor(logic [PIX_W-1:0] pix_in, logic inv);
      int unsigned     pix, r, g, b, c;
      int unsigned     vq, cq, mq, hmod, hue_dist, tri_q, xq, sector;
      int unsigned     top, mid, bot, rq, gq, bq;
      longint unsigned hq;
      pix = pix_in;
      // Inversion goes through a full repack, so the field losses apply twice.
      if (inv) begin
        r   = 255 - field_of(pix, red_shift, red_loss);
        g   = 255 - field_of(pix, green_shift, green_loss);
        b   = 255 - field_of(pix, blue_shift, blue_loss);
        pix = packed_pixel(r, g, b);
      end
      r = field_of(pix, red_shift, red_loss);
      g = field_of(pix, green_shift, green_loss);
      b = field_of(pix, blue_shift, blue_loss);
      c = r;
      if (g > c) c = g;
      if (b > c) c = b;
      vq       = 32768 + (c * 16384) / 255;
      cq       = vq / 5;
      mq       = vq - cq;
      hq       = (longint'(hue) * 6 * 65536) / HUE_STEPS_DEFAULT;
      sector   = ((hq >> 16) > 5) ? 5 : int'(hq >> 16);
      hmod     = int'(hq & 64'h1FFFF);
      hue_dist = (hmod >= 65536) ? hmod - 65536 : 65536 - hmod;
      tri_q    = 65536 - hue_dist;
      xq       = int'((longint'(cq) * tri_q) >> 16);
      top      = vq;
      mid      = xq + mq;
      bot      = mq;
      case (sector)
        0:       begin rq = top; gq = mid; bq = bot; end
        1:       begin rq = mid; gq = top; bq = bot; end
        2:       begin rq = bot; gq = top; bq = mid; end
        3:       begin rq = bot; gq = mid; bq = top; end
        4:       begin rq = mid; gq = bot; bq = top; end
        default: begin rq = top; gq = bot; bq = mid; end
      endcase
      return PIX_W'(packed_pixel(channel8(rq), channel8(gq), channel8(bq)));
    endfunction

    function void note_input(logic [PIX_W-1:0] pix, logic inv);
      expected_pixels.push_back(recolor(pix, inv));
    endfunction

    function void check_result(logic [PIX_W-1:0] actual);
      logic [PIX_W-1:0] want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected pixel_out: expected none, actual %h", $time, actual);
        return;
      end
      want = expected_pixels.pop_front();
      if (actual !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pixel_out mismatch: expected %h, actual %h", $time, want, actual);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  logic [PIX_W-1:0]      pixel_in  = '0;
  logic                  invert    = 1'b0;
  logic                  done;
  logic [PIX_W-1:0]      pixel_out;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    cycle_count = 0;

  recolor_scoreboard sb = new();

  pixel_hue_tint_recolor u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_in  (pixel_in),
    .invert    (invert),
    .done      (done),
    .pixel_out (pixel_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Values read here are the ones from before the edge, so a transfer is seen as the block saw it.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_input(pixel_in, invert);
      if (done) sb.check_result(pixel_out);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** pixel_hue_tint_recolor: FAILED **");
      $finish;
    end
  end

  // Leaves cfg_write high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Narrow registers get random upper data bits, which the block must drop.
  task automatic write_config(input tint_setup_t s);
    write_reg(REG_HUE,         s.hue);
    write_reg(REG_RED_SHIFT,   {4'($urandom), s.red_shift});
    write_reg(REG_GREEN_SHIFT, {4'($urandom), s.green_shift});
    write_reg(REG_BLUE_SHIFT,  {4'($urandom), s.blue_shift});
    write_reg(REG_RED_LOSS,    {4'($urandom), s.red_loss});
    write_reg(REG_GREEN_LOSS,  {4'($urandom), s.green_loss});
    write_reg(REG_BLUE_LOSS,   {4'($urandom), s.blue_loss});
    write_reg(REG_UNUSED,      8'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic inv);
    start    <= 1'b1;
    pixel_in <= pix;
    invert   <= inv;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic tint_setup_t random_setup();
    tint_setup_t s;
    s.hue = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: s = '{s.hue, 4'd11, 4'd5, 4'd0, 4'd3, 4'd2, 4'd3};
      1: s = '{s.hue, 4'd10, 4'd5, 4'd0, 4'd3, 4'd3, 4'd3};
      2: s = '{s.hue, 4'd0,  4'd5, 4'd11, 4'd3, 4'd2, 4'd3};
      3: s = '{s.hue, 4'd8,  4'd4, 4'd0, 4'd4, 4'd4, 4'd4};
      4: begin
        s.red_shift   = 4'($urandom);
        s.green_shift = 4'($urandom);
        s.blue_shift  = 4'($urandom);
        s.red_loss    = 4'($urandom_range(0, 8));
        s.green_loss  = 4'($urandom_range(0, 8));
        s.blue_loss   = 4'($urandom_range(0, 8));
      end
      default: begin
        s.red_shift   = 4'($urandom);
        s.green_shift = 4'($urandom);
        s.blue_shift  = 4'($urandom);
        s.red_loss    = 4'($urandom);
        s.green_loss  = 4'($urandom);
        s.blue_loss   = 4'($urandom);
      end
    endcase
    return s;
  endfunction

  logic [PIX_W-1:0] reset_pixels[8] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                        16'hF800, 16'h07E0, 16'h001F, 16'hA5A5};
  logic             reset_inverts[8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  // Hues on sector boundaries, fields past bit 15, overlapping fields and losses above 8.
  tint_setup_t corner_setups[6] = '{
    '{8'd43,  4'd11, 4'd5,  4'd0,  4'd3, 4'd2, 4'd3},
    '{8'd85,  4'd10, 4'd5,  4'd0,  4'd3, 4'd3, 4'd3},
    '{8'd128, 4'd15, 4'd4,  4'd0,  4'd0, 4'd1, 4'd2},
    '{8'd170, 4'd8,  4'd4,  4'd0,  4'd0, 4'd0, 4'd0},
    '{8'd213, 4'd11, 4'd5,  4'd0,  4'd9, 4'd15, 4'd8},
    '{8'd255, 4'd15, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0}
  };

  initial begin
    int idle_pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset layout is checked before any register is written.
    foreach (reset_pixels[i]) send_pixel(reset_pixels[i], reset_inverts[i]);
    drain();

    foreach (corner_setups[i]) begin
      write_config(corner_setups[i]);
      send_pixel(16'($urandom), 1'b0);
      send_pixel(16'($urandom), 1'b1);
      drain();
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      idle_pct = (blk < 5) ? 7 : (blk < 10) ? 49 : 0;
      write_config(random_setup());
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // Each cycle is idle with the given chance, so the idle share matches it.
        while ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        send_pixel(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      // The sender holds off here until every expected pixel has come back.
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** pixel_hue_tint_recolor: PASSED **");
    end else begin
      $display("** pixel_hue_tint_recolor: FAILED **");
    end
    $finish;
  end

endmodule

### pixel_hue_tint_recolor.f
design/phtr_pkg.sv
design/phtr_chan.sv
design/phtr_tint.sv
design/pixel_hue_tint_recolor.sv
dv/pixel_hue_tint_recolor_tb.sv
